// ----- sv/bgfb_pkg.sv -----
// Package for the bar graph framebuffer page pack block.
// Holds size defaults, operation codes, controller state and command types.
// No dependencies.
package bgfb_pkg;

    localparam int DEF_WIDTH  = 128;
    localparam int DEF_HEIGHT = 64;

    localparam int KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_POINT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BOTTOM = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CENTER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef enum logic [1:0] {
        SHAPE_POINT,
        SHAPE_BOTTOM,
        SHAPE_CENTER
    } t_shape;

    typedef struct packed {
        logic   load;
        logic   write;
        logic   clear;
        logic   emit;
        t_shape shape;
    } t_cmd;

endpackage

// ----- sv/bgfb_ctrl.sv -----
// Controller for the framebuffer block: accepts a word, then runs it in the execute state.
// Depends on bgfb_pkg for state, operation codes and the command struct.
module bgfb_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [bgfb_pkg::KIND_W-1:0] i_kind,
    output logic                       busy,
    output bgfb_pkg::t_cmd             o_cmd
);

    bgfb_pkg::t_state r_state, n_state;
    logic [bgfb_pkg::KIND_W-1:0] r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgfb_pkg::ST_IDLE;
            r_kind  <= bgfb_pkg::KIND_POINT;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        unique case (r_state)
            bgfb_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = bgfb_pkg::ST_EXEC;
                    n_kind  = i_kind;
                end
            end
            bgfb_pkg::ST_EXEC: begin
                n_state = bgfb_pkg::ST_IDLE;
            end
            default: begin
                n_state = bgfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy        = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.write = 1'b0;
        o_cmd.clear = 1'b0;
        o_cmd.emit  = 1'b0;
        o_cmd.shape = bgfb_pkg::SHAPE_POINT;
        unique case (r_state)
            bgfb_pkg::ST_IDLE: begin
                o_cmd.load = start;
            end
            bgfb_pkg::ST_EXEC: begin
                busy = 1'b1;
                unique case (r_kind)
                    bgfb_pkg::KIND_POINT: begin
                        o_cmd.write = 1'b1;
                    end
                    bgfb_pkg::KIND_BOTTOM: begin
                        o_cmd.write = 1'b1;
                        o_cmd.shape = bgfb_pkg::SHAPE_BOTTOM;
                    end
                    bgfb_pkg::KIND_CENTER: begin
                        o_cmd.write = 1'b1;
                        o_cmd.shape = bgfb_pkg::SHAPE_CENTER;
                    end
                    bgfb_pkg::KIND_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    bgfb_pkg::KIND_READ: begin
                        o_cmd.emit = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- sv/bgfb_dp.sv -----
// Datapath for the framebuffer block: column memory, valid bits, mask and page pack.
// Depends on bgfb_pkg for the command struct and shape codes.
module bgfb_dp #(
    parameter int WIDTH  = bgfb_pkg::DEF_WIDTH,
    parameter int HEIGHT = bgfb_pkg::DEF_HEIGHT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bgfb_pkg::t_cmd i_cmd,
    input  logic [6:0]     i_column,
    input  logic [5:0]     i_vertical,
    input  logic [2:0]     i_page,
    input  logic           i_color,
    output logic           o_strobe,
    output logic [7:0]     o_page_byte
);

    localparam int AW    = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int RW    = $clog2(HEIGHT);
    localparam int PAGES = HEIGHT / 8;

    logic [HEIGHT-1:0] mem [WIDTH];
    logic [WIDTH-1:0]  r_valid;

    logic [HEIGHT-1:0] r_rd;
    logic              r_rd_vld;
    logic [AW-1:0]     r_idx;
    logic              r_col_ok;
    logic [5:0]        r_vert;
    logic [2:0]        r_page;
    logic              r_color;
    logic              r_strobe;
    logic [7:0]        r_byte;

    logic [31:0]       wide_col;
    logic [AW-1:0]     idx;
    logic              col_ok;
    logic [HEIGHT-1:0] word;
    logic [HEIGHT-1:0] mask;
    logic [HEIGHT-1:0] new_word;
    logic [5:0]        lvl;
    logic [5:0]        half;
    logic [7:0]        pack;

    assign wide_col = 32'(i_column);
    assign idx      = wide_col[AW-1:0];
    assign col_ok   = wide_col < 32'(WIDTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd     <= mem[idx];
            r_idx    <= idx;
            r_col_ok <= col_ok;
            r_vert   <= i_vertical;
            r_page   <= i_page;
            r_color  <= i_color;
        end
        if (i_cmd.write && r_col_ok) begin
            mem[r_idx] <= new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_vld <= r_valid[idx];
            end
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (i_cmd.write && r_col_ok) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    assign word = r_rd_vld ? r_rd : '0;
    assign lvl  = (32'(r_vert) > 32'(HEIGHT - 1)) ? 6'(HEIGHT - 1) : r_vert;
    assign half = lvl >> 1;

    always_comb begin
        for (int r = 0; r < HEIGHT; r++) begin
            case (i_cmd.shape)
                bgfb_pkg::SHAPE_POINT:
                    mask[r] = (32'(r_vert) < 32'(HEIGHT))
                              && (32'(r) == 32'(HEIGHT - 1) - 32'(r_vert));
                bgfb_pkg::SHAPE_BOTTOM:
                    mask[r] = 32'(r) <= 32'(lvl);
                bgfb_pkg::SHAPE_CENTER:
                    mask[r] = (32'(r) >= 32'(HEIGHT / 2) - 32'(half))
                              && (32'(r) <= 32'(HEIGHT / 2) + 32'(half));
                default:
                    mask[r] = 1'b0;
            endcase
        end
    end

    assign new_word = r_color ? (word | mask) : (word & ~mask);

    always_comb begin
        int row;
        pack = '0;
        for (int k = 0; k < 8; k++) begin
            row = (PAGES - 1 - 32'(r_page)) * 8 + (7 - k);
            if (r_col_ok && 32'(r_page) < 32'(PAGES)) begin
                pack[k] = word[RW'(row)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_byte <= pack;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_page_byte = r_byte;

endmodule

// ----- sv/bar_graph_framebuffer_page_pack_core.sv -----
// Bar graph framebuffer with page byte readout; top level over bgfb_ctrl and bgfb_dp.
// Every word is handled as a column memory read, then a write-back or pack.
// No new word is accepted while busy is high, so each word is through before the next.
// A page byte appears on o_page_byte with o_strobe after the execute state and output byte register.
// Clear all is a word like the others: a row of per-column valid bits is dropped at once.
// Synchronous reset empties the framebuffer the same way; the receiver cannot stall.
module bar_graph_framebuffer_page_pack_core #(
    parameter int WIDTH  = bgfb_pkg::DEF_WIDTH,
    parameter int HEIGHT = bgfb_pkg::DEF_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bgfb_pkg::KIND_W-1:0] i_kind,
    input  logic [6:0]                  i_column,
    input  logic [5:0]                  i_vertical,
    input  logic [2:0]                  i_page,
    input  logic                        i_color,
    output logic                        o_strobe,
    output logic [7:0]                  o_page_byte
);

    bgfb_pkg::t_cmd cmd;

    bgfb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    bgfb_dp #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_column    (i_column),
        .i_vertical  (i_vertical),
        .i_page      (i_page),
        .i_color     (i_color),
        .o_strobe    (o_strobe),
        .o_page_byte (o_page_byte)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("execute longer than one cycle");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) && !busy))
        else $error("strobe without a preceding execute cycle");

    a_strobe_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!cmd.write && !cmd.clear))
        else $error("read overlaps a write or clear");

endmodule

// ----- tb/bar_graph_framebuffer_page_pack_core_tb.sv -----
// Self-checking testbench for bar_graph_framebuffer_page_pack_core.
// Mirrors the column framebuffer in a small class and checks every strobed page byte.
// Depends on bgfb_pkg and the core RTL.
module bar_graph_framebuffer_page_pack_core_tb;

    localparam int WIDTH         = bgfb_pkg::DEF_WIDTH;
    localparam int HEIGHT        = bgfb_pkg::DEF_HEIGHT;
    localparam int PAGES         = HEIGHT / 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS   = 10;

    localparam logic [bgfb_pkg::KIND_W-1:0] KIND_SPARE_LO = bgfb_pkg::KIND_READ + 3'd1;
    localparam logic [bgfb_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    class framebuffer_mirror;
        logic [HEIGHT-1:0] columns [WIDTH];
        logic [7:0]        pending_bytes [$];
        int                byte_mismatches;

        function new();
            clear_all();
            byte_mismatches = 0;
        endfunction

        function void clear_all();
            foreach (columns[i]) columns[i] = '0;
        endfunction

        function void set_pixel(int col, int row, logic color);
            if (col >= WIDTH || row < 0 || row >= HEIGHT) return;
            columns[col][row] = color;
        endfunction

        function logic [7:0] pack_byte(int col, int page);
            logic [7:0] packed_px;
            packed_px = '0;
            if (col >= WIDTH || page >= PAGES) return packed_px;
            for (int k = 0; k < 8; k++)
                packed_px[k] = columns[col][(PAGES - 1 - page) * 8 + 7 - k];
            return packed_px;
        endfunction

        function void apply_word(logic [bgfb_pkg::KIND_W-1:0] kind, logic [6:0] col,
                                 logic [5:0] vert, logic [2:0] page, logic color);
            int lvl;
            int c;
            c   = int'(col);
            lvl = (int'(vert) > HEIGHT - 1) ? HEIGHT - 1 : int'(vert);
            case (kind)
                bgfb_pkg::KIND_POINT: begin
                    if (int'(vert) < HEIGHT) set_pixel(c, HEIGHT - 1 - int'(vert), color);
                end
                bgfb_pkg::KIND_BOTTOM: begin
                    for (int i = 0; i <= lvl; i++) set_pixel(c, i, color);
                end
                bgfb_pkg::KIND_CENTER: begin
                    for (int i = 0; i <= lvl; i++) begin
                        set_pixel(c, HEIGHT / 2 + i / 2, color);
                        set_pixel(c, HEIGHT / 2 - i / 2, color);
                    end
                end
                bgfb_pkg::KIND_CLEAR: clear_all();
                bgfb_pkg::KIND_READ:  pending_bytes.push_back(pack_byte(c, int'(page)));
                default: ;
            endcase
        endfunction

        function void check_byte(logic [7:0] actual);
            logic [7:0] want;
            if (pending_bytes.size() == 0) begin
                byte_mismatches++;
                if (byte_mismatches <= MAX_REPORTS)
                    $display("page byte %02h strobed with none expected", actual);
                return;
            end
            want = pending_bytes.pop_front();
            if (actual !== want) begin
                byte_mismatches++;
                if (byte_mismatches <= MAX_REPORTS)
                    $display("page byte mismatch: expected %02h actual %02h", want, actual);
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [bgfb_pkg::KIND_W-1:0] i_kind = '0;
    logic [6:0]                  i_column = '0;
    logic [5:0]                  i_vertical = '0;
    logic [2:0]                  i_page = '0;
    logic                        i_color = 1'b0;
    logic                        o_strobe;
    logic [7:0]                  o_page_byte;

    framebuffer_mirror mirror = new();
    int                quiet_cycles = 0;

    bar_graph_framebuffer_page_pack_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_column    (i_column),
        .i_vertical  (i_vertical),
        .i_page      (i_page),
        .i_color     (i_color),
        .o_strobe    (o_strobe),
        .o_page_byte (o_page_byte)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            mirror.apply_word(i_kind, i_column, i_vertical, i_page, i_color);
        if (i_rst_n && o_strobe)
            mirror.check_byte(o_page_byte);
        if ((i_rst_n && start && !busy) || (i_rst_n && o_strobe))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_word(input logic [bgfb_pkg::KIND_W-1:0] kind, input logic [6:0] col,
                             input logic [5:0] vert, input logic [2:0] page,
                             input logic color);
        @(negedge i_clk);
        start      = 1'b1;
        i_kind     = kind;
        i_column   = col;
        i_vertical = vert;
        i_page     = page;
        i_color    = color;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start      = 1'b0;
            i_kind     = bgfb_pkg::KIND_W'($urandom_range(0, 7));
            i_column   = 7'($urandom_range(0, 127));
            i_vertical = 6'($urandom_range(0, 63));
            i_page     = 3'($urandom_range(0, 7));
            i_color    = 1'($urandom_range(0, 1));
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (mirror.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [bgfb_pkg::KIND_W-1:0] kind;
        logic [6:0]                  col;
        logic [5:0]                  vert;
        int                          pick;
        pick = $urandom_range(0, 99);
        if (pick < 24)      kind = bgfb_pkg::KIND_POINT;
        else if (pick < 44) kind = bgfb_pkg::KIND_BOTTOM;
        else if (pick < 64) kind = bgfb_pkg::KIND_CENTER;
        else if (pick < 92) kind = bgfb_pkg::KIND_READ;
        else if (pick < 95) kind = bgfb_pkg::KIND_CLEAR;
        else kind = bgfb_pkg::KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        pick = $urandom_range(0, 19);
        if (pick == 0)      col = 7'd0;
        else if (pick == 1) col = 7'd127;
        else if (pick < 12) col = 7'($urandom_range(0, 7));
        else                col = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 7);
        if (pick == 0)      vert = 6'd0;
        else if (pick == 1) vert = 6'd63;
        else                vert = 6'($urandom_range(0, 63));
        send_word(kind, col, vert, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int phase_items [3];
        int idle_odds [3];

        phase_items = '{550, 500, 300};
        idle_odds   = '{3, 8, 0};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(bgfb_pkg::KIND_READ,   7'd0,   6'd0,  3'd0, 1'b0);
        send_word(bgfb_pkg::KIND_POINT,  7'd0,   6'd0,  3'd0, 1'b1);
        send_word(bgfb_pkg::KIND_READ,   7'd0,   6'd0,  3'd0, 1'b0);
        send_word(bgfb_pkg::KIND_POINT,  7'd127, 6'd63, 3'd7, 1'b1);
        send_word(bgfb_pkg::KIND_READ,   7'd127, 6'd0,  3'd7, 1'b0);
        send_word(bgfb_pkg::KIND_BOTTOM, 7'd5,   6'd63, 3'd0, 1'b1);
        send_word(bgfb_pkg::KIND_READ,   7'd5,   6'd0,  3'd3, 1'b0);
        send_word(bgfb_pkg::KIND_BOTTOM, 7'd5,   6'd10, 3'd0, 1'b0);
        send_word(bgfb_pkg::KIND_READ,   7'd5,   6'd0,  3'd7, 1'b0);
        send_word(bgfb_pkg::KIND_READ,   7'd5,   6'd0,  3'd6, 1'b0);
        send_word(bgfb_pkg::KIND_CENTER, 7'd64,  6'd63, 3'd0, 1'b1);
        send_word(bgfb_pkg::KIND_READ,   7'd64,  6'd0,  3'd0, 1'b0);
        send_word(bgfb_pkg::KIND_READ,   7'd64,  6'd0,  3'd7, 1'b0);
        send_word(bgfb_pkg::KIND_CENTER, 7'd64,  6'd0,  3'd0, 1'b0);
        send_word(bgfb_pkg::KIND_READ,   7'd64,  6'd0,  3'd3, 1'b0);
        send_word(bgfb_pkg::KIND_CENTER, 7'd10,  6'd1,  3'd0, 1'b1);
        send_word(bgfb_pkg::KIND_READ,   7'd10,  6'd0,  3'd3, 1'b0);
        send_word(KIND_SPARE_LO, 7'd64, 6'd63, 3'd7, 1'b1);
        send_word(KIND_SPARE_HI, 7'd64, 6'd0,  3'd0, 1'b0);
        send_word(KIND_SPARE_LO + 3'd1, 7'd127, 6'd31, 3'd5, 1'b1);
        send_word(bgfb_pkg::KIND_READ,   7'd64,  6'd0,  3'd0, 1'b0);
        send_word(bgfb_pkg::KIND_CLEAR,  7'd0,   6'd0,  3'd0, 1'b0);
        send_word(bgfb_pkg::KIND_READ,   7'd64,  6'd0,  3'd0, 1'b0);
        send_word(bgfb_pkg::KIND_READ,   7'd5,   6'd0,  3'd3, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < phase_items[phase]; n++) begin
                send_random();
                if (idle_odds[phase] != 0 && $urandom_range(0, idle_odds[phase] - 1) == 0)
                    idle_cycles($urandom_range(1, 6));
                if (phase == 0 && $urandom_range(0, 99) == 0)
                    wait_drained();
            end
            if (phase < 2)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mirror.byte_mismatches == 0 && mirror.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- bar_graph_framebuffer_page_pack_core.f -----
sv/bgfb_pkg.sv
sv/bgfb_ctrl.sv
sv/bgfb_dp.sv
sv/bar_graph_framebuffer_page_pack_core.sv
tb/bar_graph_framebuffer_page_pack_core_tb.sv
